FILE: rtl/revt_pkg.sv
// Shared types and constants for the rotary encoder value tracker.
// No dependencies; every other file in rtl imports this package.
package revt_pkg;

  localparam int HISTORY_LEN = 8;

  localparam int VALUE_W = 8;
  localparam int STEP_COUNT_W = 16;
  localparam int PRESS_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [VALUE_W-1:0] STEP_SIZE_RESET = 8'd4;
  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 8'hFF;

  typedef logic [HISTORY_LEN-1:0] history_t;

  typedef enum logic [1:0] {
    MOTION_NONE = 2'd0,
    MOTION_UP   = 2'd1,
    MOTION_DOWN = 2'd2
  } motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE = 1'd0,
    REG_MAX_VALUE = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic a_level;
    logic b_level;
    logic switch_level;
  } pins_t;

  // Declared high field first so that value lands in the lowest bits.
  typedef struct packed {
    motion_t                   motion;
    logic [PRESS_W-1:0]        press_count;
    logic [STEP_COUNT_W-1:0]   step_count;
    logic [VALUE_W-1:0]        value;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

FILE: rtl/revt_decode.sv
// Encoder state, configuration registers and the per-sample update logic.
// Depends on revt_pkg.
module revt_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [revt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [revt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           sample_en,
  input  revt_pkg::pins_t                pins,
  output revt_pkg::result_t              result
);
  import revt_pkg::*;

  logic [VALUE_W-1:0]      step_size;
  logic [VALUE_W-1:0]      max_value;
  history_t                a_history;
  history_t                b_history;
  history_t                switch_history;
  logic                    armed;
  logic                    switch_armed;
  logic [VALUE_W-1:0]      tracked_value;
  logic [STEP_COUNT_W-1:0] detent_count;
  logic [PRESS_W-1:0]      presses;

  history_t                a_history_next;
  history_t                b_history_next;
  history_t                switch_history_next;
  logic                    armed_next;
  logic                    switch_armed_next;
  logic [VALUE_W-1:0]      tracked_value_next;
  logic [STEP_COUNT_W-1:0] detent_count_next;
  logic [PRESS_W-1:0]      presses_next;
  motion_t                 motion;
  logic [VALUE_W:0]        sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_SIZE_RESET;
      max_value <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_SIZE: step_size <= cfg_data;
        REG_MAX_VALUE: max_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_history_next      = history_t'({a_history, ~pins.a_level});
    b_history_next      = history_t'({b_history, ~pins.b_level});
    switch_history_next = history_t'({switch_history, ~pins.switch_level});

    sum                = {1'b0, tracked_value} + {1'b0, step_size};
    tracked_value_next = tracked_value;
    detent_count_next  = detent_count;
    armed_next         = armed;
    motion             = MOTION_NONE;

    if (armed) begin
      if (a_history_next != '0) begin
        tracked_value_next = (sum > {1'b0, max_value}) ? max_value : sum[VALUE_W-1:0];
        detent_count_next  = detent_count + STEP_COUNT_W'(1);
        motion             = MOTION_UP;
        armed_next         = 1'b0;
      end else if (b_history_next != '0) begin
        tracked_value_next = (tracked_value >= step_size) ? tracked_value - step_size : '0;
        detent_count_next  = detent_count - STEP_COUNT_W'(1);
        motion             = MOTION_DOWN;
        armed_next         = 1'b0;
      end
    end else if (a_history_next == '0 && b_history_next == '0) begin
      armed_next = 1'b1;
    end

    presses_next      = presses;
    switch_armed_next = switch_armed;
    if (switch_armed) begin
      if (switch_history_next != '0) begin
        switch_armed_next = 1'b0;
        presses_next      = presses + PRESS_W'(1);
      end
    end else if (switch_history_next == '0) begin
      switch_armed_next = 1'b1;
    end

    result.value       = tracked_value_next;
    result.step_count  = detent_count_next;
    result.press_count = presses_next;
    result.motion      = motion;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_history      <= '0;
      b_history      <= '0;
      switch_history <= '0;
      armed          <= 1'b0;
      switch_armed   <= 1'b0;
      tracked_value  <= '0;
      detent_count   <= '0;
      presses        <= '0;
    end else if (sample_en) begin
      a_history      <= a_history_next;
      b_history      <= b_history_next;
      switch_history <= switch_history_next;
      armed          <= armed_next;
      switch_armed   <= switch_armed_next;
      tracked_value  <= tracked_value_next;
      detent_count   <= detent_count_next;
      presses        <= presses_next;
    end
  end

endmodule

FILE: rtl/revt_obuf.sv
// Result register with a skid stage, so a request can be taken while a result waits.
// Depends on revt_pkg.
module revt_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  revt_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output revt_pkg::result_t out_data
);
  import revt_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

FILE: rtl/rotary_encoder_value_tracker_core.sv
// Top level of the rotary encoder value tracker: stream ports and configuration port.
// Depends on revt_pkg, revt_decode and revt_obuf.
//
// Each request carries one sample of the active-low A, B and switch pins and yields
// exactly one registered result. A new request is taken every cycle while the skid
// stage is empty; the state update and saturating add or subtract are combinational
// ahead of the result register and its skid stage, so s_tready drops only after the
// result side stalls. The user must write step_size and max_value through cfg_we,
// cfg_index and cfg_data while no request is in flight; the block does not enforce it.
module rotary_encoder_value_tracker_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: a_level, b_level, switch_level, zero padding.
  input  logic [revt_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: value[7:0], step_count[15:0], press_count[7:0], motion[1:0],
  // zero padding.
  output logic [revt_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [revt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [revt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import revt_pkg::*;

  pins_t   pins;
  result_t result;
  result_t out_result;
  logic    sample_en;

  assign pins.a_level      = s_tdata[0];
  assign pins.b_level      = s_tdata[1];
  assign pins.switch_level = s_tdata[2];
  assign sample_en         = s_tvalid && s_tready;
  assign m_tdata           = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_result};

  revt_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_en (sample_en),
    .pins      (pins),
    .result    (result)
  );

  revt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

endmodule
